// File: sv/merge_insertion_sorter_assert.svh
// Assertion macros for the merge insertion sorter.
`ifndef MERGE_INSERTION_SORTER_ASSERT_SVH
`define MERGE_INSERTION_SORTER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MSORT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("merge_insertion_sorter: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define MSORT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("merge_insertion_sorter: next-cycle check failed");

`endif

// File: sv/msort_pkg.sv
// Shared constants and types of the merge insertion sorter.
`timescale 1ns / 1ps

package msort_pkg;

  localparam int unsigned MAX_COUNT_DEF  = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic load;   // insert the incoming item at its sorted place
    logic shift;  // move every value one cell toward the output
  } ctl_t;

endpackage

// File: sv/msort_cell.sv
// One cell of the sorting chain: holds one value and its valid bit.
`timescale 1ns / 1ps

module msort_cell #(
  parameter int unsigned DATA_WIDTH = msort_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  msort_pkg::ctl_t              ctl,
  input  logic signed [DATA_WIDTH-1:0] ins_val,
  input  logic signed [DATA_WIDTH-1:0] left_val,
  input  logic                         left_vld,
  input  logic                         left_keep,
  input  logic signed [DATA_WIDTH-1:0] right_val,
  input  logic                         right_vld,
  output logic signed [DATA_WIDTH-1:0] val,
  output logic                         vld,
  output logic                         keep
);
  import msort_pkg::*;

  logic signed [DATA_WIDTH-1:0] val_r;
  logic signed [DATA_WIDTH-1:0] val_nxt;
  logic                         vld_r;
  logic                         vld_nxt;

  // Keep the held value when it is not greater than the new one (stable for duplicates)
  assign keep = vld_r && !(ins_val < val_r);

  // Pick the next content: unload shift, or insert / shift right past the insertion point
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.shift) begin
      val_nxt = right_val;
      vld_nxt = right_vld;
    end else if (ctl.load && !keep) begin
      val_nxt = left_keep ? ins_val : left_val;
      vld_nxt = vld_r | left_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

// File: sv/merge_insertion_sorter.sv
// Latency: the first result is offered in the cycle after the closing item is taken.
// Throughput: one item per cycle while loading, one result per cycle while unloading
// and out_tready is high; loading and unloading share the one cell chain.
// The chain does not take new items while it unloads a run.
// Reset (rst_n low, synchronous) empties every cell and clears the dropped flag
// at once; no clearing pass is needed.
`timescale 1ns / 1ps

module merge_insertion_sorter #(
  parameter int unsigned MAX_COUNT  = msort_pkg::MAX_COUNT_DEF,
  parameter int unsigned DATA_WIDTH = msort_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]     in_tdata,   // value
  input  logic                                in_tlast,   // last
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]     out_tdata,  // value_res
  output logic                                out_tlast,  // last_res
  output logic                                out_tuser   // dropped
);
  import msort_pkg::*;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t                       state_r;
  state_t                       state_nxt;
  logic                         ovf_r;
  logic                         ovf_nxt;

  logic signed [DATA_WIDTH-1:0] in_val;
  logic signed [DATA_WIDTH-1:0] cell_val  [MAX_COUNT];
  logic                         cell_vld  [MAX_COUNT];
  logic                         cell_keep [MAX_COUNT];
  logic                         full;
  logic                         in_acc;
  logic                         out_acc;
  ctl_t                         ctl;

  assign in_val  = in_tdata[DATA_WIDTH-1:0];
  assign full    = cell_vld[MAX_COUNT-1];
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Broadcast command: insert when room is left, shift while unloading
  assign ctl.load  = in_acc && !full;
  assign ctl.shift = out_acc;

  // Build the chain; cell 0 sits at the output end and holds the smallest value
  for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] l_val;
    logic                         l_vld;
    logic                         l_keep;
    logic signed [DATA_WIDTH-1:0] r_val;
    logic                         r_vld;

    if (i == 0) begin : g_head
      assign l_val  = '0;
      assign l_vld  = 1'b1;
      assign l_keep = 1'b1;
    end else begin : g_mid
      assign l_val  = cell_val[i-1];
      assign l_vld  = cell_vld[i-1];
      assign l_keep = cell_keep[i-1];
    end

    if (i == MAX_COUNT - 1) begin : g_tail
      assign r_val = '0;
      assign r_vld = 1'b0;
    end else begin : g_body
      assign r_val = cell_val[i+1];
      assign r_vld = cell_vld[i+1];
    end

    msort_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .ins_val   (in_val),
      .left_val  (l_val),
      .left_vld  (l_vld),
      .left_keep (l_keep),
      .right_val (r_val),
      .right_vld (r_vld),
      .val       (cell_val[i]),
      .vld       (cell_vld[i]),
      .keep      (cell_keep[i])
    );
  end

  // Sequence load and unload; track items dropped for lack of room
  always_comb begin
    state_nxt = state_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          ovf_nxt = ovf_r | full;
          if (in_tlast) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc && out_tlast) begin
          state_nxt = ST_LOAD;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Output straight from the head cell
  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_DRAIN) && cell_vld[0];
  assign out_tlast  = !cell_vld[1];
  assign out_tuser  = ovf_r;

  always_comb begin
    out_tdata                 = '0;
    out_tdata[DATA_WIDTH-1:0] = cell_val[0];
  end

`include "merge_insertion_sorter_assert.svh"

  `MSORT_ASSERT_SAME(a_no_overlap, in_tready, !out_tvalid)
  `MSORT_ASSERT_NEXT(a_close_starts_out, in_acc && in_tlast, out_tvalid)
  `MSORT_ASSERT_NEXT(a_end_reopens_in, out_acc && out_tlast, in_tready && !cell_vld[0])
  `MSORT_ASSERT_NEXT(a_drop_sets_flag, in_acc && full, ovf_r)

endmodule

// File: dv/merge_insertion_sorter_tb.sv
// Self-checking testbench for the merge insertion sorter: runs in, sorted runs out.
`timescale 1ns / 1ps

module merge_insertion_sorter_tb;
  import msort_pkg::*;

  localparam int unsigned DW         = DATA_WIDTH_DEF;
  localparam int unsigned TW         = ((DW + 7) / 8) * 8;
  localparam int unsigned RUN_CAP    = MAX_COUNT_DEF;
  localparam int          IDLE_LIMIT = 1000;
  localparam int          DRAIN      = 20;
  localparam int          ITEM_GOAL  = 130;

  localparam logic [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef logic [DW-1:0] word_q_t[$];

  // Predict the sorted output of each run and check the block against it.
  class sort_scoreboard;
    typedef struct {
      logic [DW-1:0] value;
      logic          last;
      logic          dropped;
    } sorted_item_t;

    logic [DW-1:0] run_values[$];
    bit            run_overflow;
    sorted_item_t  sorted_due[$];
    int            mismatches;

    // Store or drop one accepted value; on the closing item, queue the sorted run.
    function void note_value(logic [DW-1:0] value, logic last);
      logic [DW-1:0] ordered[$];
      sorted_item_t  item;
      int            pos;
      if (run_values.size() < RUN_CAP) run_values.insert(run_values.size(), value);
      else run_overflow = 1'b1;
      if (!last) return;
      // Insert each value before the first entry that is not less than it.
      foreach (run_values[i]) begin
        pos = 0;
        while (pos < ordered.size() && $signed(ordered[pos]) < $signed(run_values[i])) pos++;
        ordered.insert(pos, run_values[i]);
      end
      foreach (ordered[i]) begin
        item.value   = ordered[i];
        item.last    = (i == ordered.size() - 1);
        item.dropped = run_overflow;
        sorted_due.insert(sorted_due.size(), item);
      end
      run_values.delete();
      run_overflow = 1'b0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Compare one accepted result with the oldest sorted value due.
    function void check_sorted(logic [TW-1:0] data, logic last, logic dropped);
      sorted_item_t want;
      if (sorted_due.size() == 0) begin
        report($sformatf("unexpected result value=%0d last=%b dropped=%b",
                         $signed(data[DW-1:0]), last, dropped));
        return;
      end
      want = sorted_due.pop_front();
      if (data[DW-1:0] !== want.value)
        report($sformatf("value: expected %0d, got %0d",
                         $signed(want.value), $signed(data[DW-1:0])));
      if (last !== want.last)
        report($sformatf("last: expected %b, got %b (value %0d)",
                         want.last, last, $signed(want.value)));
      if (dropped !== want.dropped)
        report($sformatf("dropped: expected %b, got %b (value %0d)",
                         want.dropped, dropped, $signed(want.value)));
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [TW-1:0] in_tdata;   // value
  logic          in_tlast;   // last
  logic          out_tvalid;
  logic          out_tready;
  logic [TW-1:0] out_tdata;  // value_res
  logic          out_tlast;  // last_res
  logic          out_tuser;  // dropped

  sort_scoreboard sb = new();
  int             idle_cycles = 0;

  merge_insertion_sorter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Watch both channels, feed the scoreboard and guard against a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_value(in_tdata[DW-1:0], in_tlast);
      if (out_tvalid && out_tready) sb.check_sorted(out_tdata, out_tlast, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Draw a value: half full-range, some near zero, some at or near the extremes.
  function automatic logic [DW-1:0] pick_value();
    logic [DW-1:0] extreme_vals[4];
    extreme_vals = '{VAL_MAX, VAL_MIN, '0, '1};
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom;
      3:       return DW'(int'($urandom_range(0, 16)) - 8);
      4:       return extreme_vals[$urandom_range(0, 3)];
      default: return $urandom_range(0, 1) ? VAL_MAX - $urandom_range(0, 3)
                                           : VAL_MIN + $urandom_range(0, 3);
    endcase
  endfunction

  // Offer one item after an optional gap and hold it until taken.
  task automatic send_item(input logic [DW-1:0] value, input logic last, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TW'(value);
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Send a whole run, closing it on its final value.
  task automatic send_run(input word_q_t vals);
    bit no_gap;
    no_gap = ($urandom_range(0, 3) == 0);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1, no_gap);
  endtask

  task automatic send_random_run(input int len, inout int sent);
    word_q_t vals;
    repeat (len) vals.insert(vals.size(), pick_value());
    send_run(vals);
    sent += len;
  endtask

  // Stall the result channel at random, with stretches of steady acceptance.
  initial begin
    int stall;
    bit steady;
    out_tready = 1'b0;
    steady     = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Drive reset, directed runs, then random runs, and judge the outcome.
  initial begin
    word_q_t run;
    int      sent;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    rst_n       = 1'b0;
    sent        = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Single-value run.
    run = '{DW'(5)};
    send_run(run);
    // Two values in descending order, at the extremes.
    run = '{VAL_MAX, VAL_MIN};
    send_run(run);
    // Odd count with a trailing negative value.
    run = '{DW'(3), DW'(9), DW'(-5)};
    send_run(run);
    // Extremes, neighbors of the extremes and a duplicate zero.
    run = '{'1, '0, VAL_MAX, VAL_MIN, DW'(1), VAL_MIN + 1, VAL_MAX - 1, '0};
    send_run(run);
    // All duplicates, then all negative.
    run = '{DW'(4), DW'(4), DW'(4)};
    send_run(run);
    run = '{DW'(-2), DW'(-7)};
    send_run(run);

    // Fill the store exactly, then overflow it so the closing value is dropped.
    send_random_run(RUN_CAP, sent);
    send_random_run(RUN_CAP + $urandom_range(1, 6), sent);
    while (sent < ITEM_GOAL) send_random_run($urandom_range(1, 12), sent);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.sorted_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/msort_pkg.sv
sv/msort_cell.sv
sv/merge_insertion_sorter.sv
dv/merge_insertion_sorter_tb.sv
